// ----- hdl/i2c_register_transaction_sequencer_macros.svh -----
// Assertion macros shared by the register transaction sequencer modules.
// Both macros expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define I2CRTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define I2CRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2crts_pkg.sv -----
// Types, codes and sizing constants of the I2C register transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2crts_pkg;

    // Sizing
    localparam int PAGE_BYTES     = 8;
    localparam int MAX_READ_BYTES = 256;
    localparam int PAGE_IDX_W     = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int CNT_W          = $clog2(MAX_READ_BYTES + 1);

    // Port widths
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_RETRY_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_PRE_DELAY   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] RST_RETRY_DELAY      = 16'd100;
    localparam logic [15:0] RST_READ_RETRY_DELAY = 16'd10;
    localparam logic [15:0] RST_READ_PRE_DELAY   = 16'd100;

    // Controller status codes
    localparam logic [7:0] ST_RESTART_OK = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_NACKED  = 8'h58;

    typedef enum logic [1:0] {
        KIND_REQ   = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_LOAD  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SEQ   = 2'd2,
        OP_PAGE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_RX_ACK  = 3'd4,
        CMD_RX_NACK = 3'd5,
        CMD_STOP    = 3'd6,
        CMD_DELAY   = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_SLA_W_NACK  = 3'd1,
        ERR_REG_NACK    = 3'd2,
        ERR_RESTART     = 3'd3,
        ERR_SLA_R_NACK  = 3'd4,
        ERR_READ_STATUS = 3'd5,
        ERR_DATA_NACK   = 3'd6
    } err_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_PRE_DELAY = 4'd1,
        PH_START     = 4'd2,
        PH_SLA_W     = 4'd3,
        PH_REG       = 4'd4,
        PH_DATA_W    = 4'd5,
        PH_RESTART   = 4'd6,
        PH_SLA_R     = 4'd7,
        PH_RB_DATA   = 4'd8,
        PH_SEQ_DATA  = 4'd9,
        PH_PAGE_DATA = 4'd10,
        PH_RETRY     = 4'd11
    } phase_t;

    // One result word
    typedef struct packed {
        logic        transaction_done;
        err_t        error_code;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic [15:0] delay_ticks;
        logic [7:0]  tx_byte;
        cmd_t        command;
        logic        last_of_run;
    } result_t;

    // Results produced by one input word, r0 first
    typedef struct packed {
        logic [1:0] n;
        result_t    r1;
        result_t    r0;
    } push_t;

endpackage

`default_nettype wire

// ----- hdl/i2crts_ctrl.sv -----
// Input register, configuration registers, page buffer and transaction state machine.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_transaction_sequencer_macros.svh"

module i2crts_ctrl import i2crts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  space_ok,
    output push_t                 push
);

    // Input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [KIND_W-1:0]    in_kind_reg;
    logic                 fire;

    // Configuration
    logic [15:0] retry_delay_reg;
    logic [15:0] read_retry_delay_reg;
    logic [15:0] read_pre_delay_reg;

    // Transaction state
    phase_t                phase_reg, phase_next;
    op_t                   op_reg, op_next;
    logic [7:0]            sla_reg, sla_next;
    logic [7:0]            reg_addr_reg, reg_addr_next;
    logic [7:0]            wbyte_reg, wbyte_next;
    logic [CNT_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [PAGE_IDX_W-1:0] page_idx_reg, page_idx_next;
    logic [PAGE_IDX_W-1:0] load_ptr_reg, load_ptr_next;
    logic                  nack_seen_reg, nack_seen_next;
    logic [7:0]            page_buf [PAGE_BYTES];
    logic                  load_we;

    // Fields of the held word
    kind_t       f_kind;
    op_t         f_op;
    logic [7:0]  f_sla;
    logic [7:0]  f_reg;
    logic [7:0]  f_data;
    logic [8:0]  f_cnt;
    logic [7:0]  f_status;
    logic [7:0]  f_rx;

    logic [CNT_W-1:0]      cnt_sat;
    logic [CNT_W-1:0]      left_dec;
    logic [PAGE_IDX_W-1:0] page_idx_inc;
    logic                  nack_now;
    logic [15:0]           fail_delay;

    assign f_kind   = kind_t'(in_kind_reg);
    assign f_op     = op_t'(in_data_reg[1:0]);
    assign f_sla    = in_data_reg[9:2];
    assign f_reg    = in_data_reg[17:10];
    assign f_data   = in_data_reg[25:18];
    assign f_cnt    = in_data_reg[34:26];
    assign f_status = in_data_reg[42:35];
    assign f_rx     = in_data_reg[50:43];

    // Process the held word when the queue has room for two results
    assign fire     = in_valid_reg && space_ok;
    assign s_tready = !in_valid_reg || space_ok;

    function automatic result_t mk_res(cmd_t cmd, logic [7:0] tx, logic [15:0] dly,
                                       logic [7:0] rx, logic rxv, err_t err, logic done);
        result_t r;
        r                  = '0;
        r.command          = cmd;
        r.tx_byte          = tx;
        r.delay_ticks      = dly;
        r.rx_byte          = rx;
        r.rx_valid         = rxv;
        r.error_code       = err;
        r.transaction_done = done;
        return r;
    endfunction

    function automatic push_t push_one(result_t r);
        push_t p;
        p                = '0;
        p.n              = 2'd1;
        p.r0             = r;
        p.r0.last_of_run = 1'b1;
        return p;
    endfunction

    // Error stop followed by the retry delay
    function automatic push_t push_fail(err_t e, logic [15:0] d);
        push_t p;
        p                = '0;
        p.n              = 2'd2;
        p.r0             = mk_res(CMD_STOP, 8'd0, 16'd0, 8'd0, 1'b0, e, 1'b0);
        p.r1             = mk_res(CMD_DELAY, 8'd0, d, 8'd0, 1'b0, ERR_NONE, 1'b0);
        p.r1.last_of_run = 1'b1;
        return p;
    endfunction

    // First command of an attempt: byte read opens with a delay
    function automatic result_t attempt_res(op_t op, logic [15:0] pre);
        result_t r;
        if (op == OP_READ) begin
            r = mk_res(CMD_DELAY, 8'd0, pre, 8'd0, 1'b0, ERR_NONE, 1'b0);
        end else begin
            r = mk_res(CMD_START, 8'd0, 16'd0, 8'd0, 1'b0, ERR_NONE, 1'b0);
        end
        return r;
    endfunction

    // Clamp the requested read length to 1 .. MAX_READ_BYTES
    always_comb begin
        if (f_cnt == 9'd0) begin
            cnt_sat = CNT_W'(1);
        end else if (32'(f_cnt) > 32'(MAX_READ_BYTES)) begin
            cnt_sat = CNT_W'(MAX_READ_BYTES);
        end else begin
            cnt_sat = CNT_W'(f_cnt);
        end
    end

    assign left_dec     = (bytes_left_reg != '0) ? bytes_left_reg - CNT_W'(1) : '0;
    assign page_idx_inc = PAGE_IDX_W'(page_idx_reg + 1'b1);
    assign nack_now     = nack_seen_reg || (f_status == ST_DATA_NACK);
    assign fail_delay   = (op_reg == OP_READ) ? read_retry_delay_reg : retry_delay_reg;

    // Next state and results
    always_comb begin
        phase_next      = phase_reg;
        op_next         = op_reg;
        sla_next        = sla_reg;
        reg_addr_next   = reg_addr_reg;
        wbyte_next      = wbyte_reg;
        bytes_left_next = bytes_left_reg;
        page_idx_next   = page_idx_reg;
        load_ptr_next   = load_ptr_reg;
        nack_seen_next  = nack_seen_reg;
        load_we         = 1'b0;
        push            = '0;
        if (fire) begin
            unique case (f_kind)
                KIND_REQ: begin
                    if (phase_reg == PH_IDLE) begin
                        op_next         = f_op;
                        sla_next        = f_sla;
                        reg_addr_next   = f_reg;
                        wbyte_next      = f_data;
                        bytes_left_next = cnt_sat;
                        phase_next      = (f_op == OP_READ) ? PH_PRE_DELAY : PH_START;
                        push            = push_one(attempt_res(f_op, read_pre_delay_reg));
                    end
                end
                KIND_LOAD: begin
                    if (phase_reg == PH_IDLE) begin
                        load_we = 1'b1;
                        if (load_ptr_reg == PAGE_IDX_W'(PAGE_BYTES - 1)) begin
                            load_ptr_next = '0;
                        end else begin
                            load_ptr_next = PAGE_IDX_W'(load_ptr_reg + 1'b1);
                        end
                    end
                end
                KIND_EVENT: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                        end
                        PH_PRE_DELAY: begin
                            phase_next = PH_START;
                            push = push_one(mk_res(CMD_START, 8'd0, 16'd0, 8'd0, 1'b0,
                                                   ERR_NONE, 1'b0));
                        end
                        PH_START: begin
                            phase_next = PH_SLA_W;
                            push = push_one(mk_res(CMD_SEND, sla_reg, 16'd0, 8'd0, 1'b0,
                                                   ERR_NONE, 1'b0));
                        end
                        PH_SLA_W: begin
                            if (f_status != ST_SLA_W_ACK) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_SLA_W_NACK, fail_delay);
                            end else begin
                                phase_next = PH_REG;
                                push = push_one(mk_res(CMD_SEND, reg_addr_reg, 16'd0, 8'd0,
                                                       1'b0, ERR_NONE, 1'b0));
                            end
                        end
                        PH_REG: begin
                            if (f_status != ST_DATA_ACK) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_REG_NACK, fail_delay);
                            end else if (op_reg == OP_WRITE) begin
                                phase_next = PH_DATA_W;
                                push = push_one(mk_res(CMD_SEND, wbyte_reg, 16'd0, 8'd0,
                                                       1'b0, ERR_NONE, 1'b0));
                            end else if (op_reg == OP_PAGE) begin
                                page_idx_next  = '0;
                                nack_seen_next = 1'b0;
                                phase_next     = PH_PAGE_DATA;
                                push = push_one(mk_res(CMD_SEND, page_buf[0], 16'd0, 8'd0,
                                                       1'b0, ERR_NONE, 1'b0));
                            end else begin
                                phase_next = PH_RESTART;
                                push = push_one(mk_res(CMD_RESTART, 8'd0, 16'd0, 8'd0,
                                                       1'b0, ERR_NONE, 1'b0));
                            end
                        end
                        PH_DATA_W: begin
                            if (f_status != ST_DATA_ACK) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_DATA_NACK, fail_delay);
                            end else begin
                                phase_next = PH_IDLE;
                                push = push_one(mk_res(CMD_STOP, 8'd0, 16'd0, 8'd0, 1'b0,
                                                       ERR_NONE, 1'b1));
                            end
                        end
                        PH_RESTART: begin
                            if (f_status != ST_RESTART_OK) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_RESTART, fail_delay);
                            end else begin
                                phase_next = PH_SLA_R;
                                push = push_one(mk_res(CMD_SEND, sla_reg | 8'h01, 16'd0,
                                                       8'd0, 1'b0, ERR_NONE, 1'b0));
                            end
                        end
                        PH_SLA_R: begin
                            if (f_status != ST_SLA_R_ACK) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_SLA_R_NACK, fail_delay);
                            end else if (op_reg == OP_READ) begin
                                phase_next = PH_RB_DATA;
                                push = push_one(mk_res(CMD_RX_NACK, 8'd0, 16'd0, 8'd0,
                                                       1'b0, ERR_NONE, 1'b0));
                            end else begin
                                phase_next = PH_SEQ_DATA;
                                push = push_one(mk_res(
                                    (bytes_left_reg > CNT_W'(1)) ? CMD_RX_ACK : CMD_RX_NACK,
                                    8'd0, 16'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
                            end
                        end
                        PH_RB_DATA: begin
                            if (f_status != ST_RX_NACKED) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_READ_STATUS, fail_delay);
                            end else begin
                                phase_next = PH_IDLE;
                                push = push_one(mk_res(CMD_STOP, 8'd0, 16'd0, f_rx, 1'b1,
                                                       ERR_NONE, 1'b1));
                            end
                        end
                        PH_SEQ_DATA: begin
                            // Status is not checked; every receive hands a byte out
                            bytes_left_next = left_dec;
                            if (left_dec == '0) begin
                                phase_next = PH_IDLE;
                                push = push_one(mk_res(CMD_STOP, 8'd0, 16'd0, f_rx, 1'b1,
                                                       ERR_NONE, 1'b1));
                            end else begin
                                push = push_one(mk_res(
                                    (left_dec > CNT_W'(1)) ? CMD_RX_ACK : CMD_RX_NACK,
                                    8'd0, 16'd0, f_rx, 1'b1, ERR_NONE, 1'b0));
                            end
                        end
                        PH_PAGE_DATA: begin
                            // Send the whole page; a nack only fails at the end
                            nack_seen_next = nack_now;
                            if (page_idx_reg != PAGE_IDX_W'(PAGE_BYTES - 1)) begin
                                page_idx_next = page_idx_inc;
                                push = push_one(mk_res(CMD_SEND, page_buf[page_idx_inc],
                                                       16'd0, 8'd0, 1'b0, ERR_NONE, 1'b0));
                            end else if (nack_now) begin
                                phase_next = PH_RETRY;
                                push       = push_fail(ERR_DATA_NACK, fail_delay);
                            end else begin
                                load_ptr_next = '0;
                                phase_next    = PH_IDLE;
                                push = push_one(mk_res(CMD_STOP, 8'd0, 16'd0, 8'd0, 1'b0,
                                                       ERR_NONE, 1'b1));
                            end
                        end
                        PH_RETRY: begin
                            phase_next = (op_reg == OP_READ) ? PH_PRE_DELAY : PH_START;
                            push       = push_one(attempt_res(op_reg, read_pre_delay_reg));
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_delay_reg      <= RST_RETRY_DELAY;
            read_retry_delay_reg <= RST_READ_RETRY_DELAY;
            read_pre_delay_reg   <= RST_READ_PRE_DELAY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RETRY_DELAY:      retry_delay_reg      <= cfg_data;
                CFG_READ_RETRY_DELAY: read_retry_delay_reg <= cfg_data;
                CFG_READ_PRE_DELAY:   read_pre_delay_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            op_reg         <= OP_WRITE;
            bytes_left_reg <= '0;
            page_idx_reg   <= '0;
            load_ptr_reg   <= '0;
            nack_seen_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            op_reg         <= op_next;
            bytes_left_reg <= bytes_left_next;
            page_idx_reg   <= page_idx_next;
            load_ptr_reg   <= load_ptr_next;
            nack_seen_reg  <= nack_seen_next;
        end
    end

    // Saved request bytes and page buffer
    always_ff @(posedge aclk) begin
        sla_reg      <= sla_next;
        reg_addr_reg <= reg_addr_next;
        wbyte_reg    <= wbyte_next;
        if (load_we) begin
            page_buf[load_ptr_reg] <= f_data;
        end
    end

    `I2CRTS_ASSERT_SAME(a_push_needs_fire, push.n != 2'd0, fire, "result without a word")
    `I2CRTS_ASSERT_SAME(a_pair_is_error, push.n == 2'd2,
        push.r0.command == CMD_STOP && push.r0.error_code != ERR_NONE &&
        push.r1.command == CMD_DELAY && phase_next == PH_RETRY, "bad error pair")
    `I2CRTS_ASSERT_NEXT(a_done_goes_idle, push.n == 2'd1 && push.r0.transaction_done,
        phase_reg == PH_IDLE, "done without idle")

endmodule

`default_nettype wire

// ----- hdl/i2crts_rqueue.sv -----
// Small result queue taking up to two results a cycle and handing out one while m_tready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_transaction_sequencer_macros.svh"

module i2crts_rqueue import i2crts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    space_ok,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t head
);

    result_t             mem [RQ_DEPTH];
    logic [RQ_CNT_W-1:0] count_reg, count_next;
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_PTR_W-1:0] wr_ptr_alt;
    logic                pop;

    assign m_tvalid = count_reg != '0;
    assign head     = mem[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;
    assign space_ok = count_reg <= RQ_CNT_W'(RQ_DEPTH - 2);

    // Advance pointers and the fill count
    assign wr_ptr_alt  = RQ_PTR_W'(wr_ptr_reg + 1'b1);
    assign wr_ptr_next = RQ_PTR_W'(wr_ptr_reg + RQ_PTR_W'(push.n));
    assign rd_ptr_next = RQ_PTR_W'(rd_ptr_reg + RQ_PTR_W'(pop));
    assign count_next  = RQ_CNT_W'(count_reg + RQ_CNT_W'(push.n) - RQ_CNT_W'(pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the pushed words in order
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_alt] <= push.r1;
        end
    end

    `I2CRTS_ASSERT_SAME(a_push_has_room, push.n != 2'd0,
        count_reg <= RQ_CNT_W'(RQ_DEPTH - 2), "queue overflow")
    `I2CRTS_ASSERT_NEXT(a_pop_drains, pop && push.n == 2'd0,
        count_reg == RQ_CNT_W'($past(count_reg) - 1'b1), "pop did not drain")

endmodule

`default_nettype wire

// ----- hdl/i2c_register_transaction_sequencer.sv -----
// Top level of the I2C register transaction sequencer.
//
// Sequences byte write, byte read, sequential read and page write transactions
// for a byte-level I2C controller. Each input word (s_tuser = kind) is a request,
// a controller completion event or a page byte load; a request taken while idle
// and an event during a transaction each yield one result word carrying the next
// bus command, or two on an error (error stop, then the retry delay). Requests
// and page loads during a transaction, events while idle and the unused kind code
// are dropped without a result. m_tlast marks the final result of an input word.
// An input word is taken into an input register, decoded by one level of
// state-machine logic and its results written into a four-word result queue once
// the queue has room for two, so one word a cycle is accepted as long as the queue
// holds at most two words.
// Configuration writes are always accepted and should be made while no
// transaction is running.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transaction_sequencer import i2crts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operation[1:0], slave_addr[9:2], reg_addr[17:10], data_byte[25:18],
    // byte_count[34:26], bus_status[42:35], bus_rx_byte[50:43], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // command[2:0], tx_byte[10:3], delay_ticks[26:11], rx_byte[34:27],
    // rx_valid[35], error_code[38:36], transaction_done[39]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    push_t   push;
    logic    space_ok;
    result_t head;

    assign cfg_ready = 1'b1;

    i2crts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .space_ok  (space_ok),
        .push      (push)
    );

    i2crts_rqueue u_rqueue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the head result word
    assign m_tdata = {head.transaction_done, head.error_code, head.rx_valid, head.rx_byte,
                      head.delay_ticks, head.tx_byte, head.command};
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire
